[sv/dtcp_pkg.sv]
// Shared types, widths and constants of the depth-to-colored-point core.
`default_nettype none

package dtcp_pkg;

  // Frame geometry
  localparam int unsigned MaxDim  = 4096;
  localparam int unsigned CntW    = $clog2(MaxDim);
  localparam int unsigned FrameW  = 13;
  localparam int unsigned LimW    = (CntW + 1 > FrameW) ? CntW + 1 : FrameW;

  // Field widths
  localparam int unsigned CenterW    = 16;
  localparam int unsigned ScaleW     = 40;
  localparam int unsigned ScaleHalfW = ScaleW / 2;
  localparam int unsigned OrderW     = 2;
  localparam int unsigned DepthW     = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned ZW         = 23;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 40;

  // Projection datapath: offset is Q.4, product Q.44, result Q16.16
  localparam int unsigned SubPixW = 4;
  localparam int unsigned PosW    = CntW + SubPixW;
  localparam int unsigned MagW    = (PosW > CenterW) ? PosW : CenterW;
  localparam int unsigned ProdW   = MagW + DepthW;
  localparam int unsigned AW      = ProdW + ScaleHalfW;
  localparam int unsigned ASplit  = 8;
  localparam int unsigned AHiW    = AW - ASplit;
  localparam int unsigned LowW    = AW + 1;
  localparam int unsigned DropW   = 28;
  localparam int unsigned LowHiW  = LowW - DropW;
  localparam int unsigned QW      = AHiW + 1;

  // z = round(depth * 65536 / 1000) = floor((depth * 8192 + 62) / 125),
  // the division done as a multiply by ceil(2^37 / 125)
  localparam int unsigned ZFracW  = 13;
  localparam int unsigned ZNumW   = DepthW + ZFracW;
  localparam int unsigned ZRecipW = 31;
  localparam int unsigned ZShift  = 37;
  localparam int unsigned ZProdW  = ZNumW + ZRecipW;
  localparam logic [ZRecipW-1:0] ZRecip = 31'd1099511628;
  localparam logic [ZNumW-1:0]   ZBias  = 29'd62;

  // Queues
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned OutDepth = 8;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegCenterX     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegScaleX      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegScaleY      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 3'd5;
  localparam logic [CfgIdxW-1:0] RegColorOrder  = 3'd6;

  // Color routing codes
  localparam logic [OrderW-1:0] ColorRgb  = 2'd0;
  localparam logic [OrderW-1:0] ColorBgr  = 2'd1;
  localparam logic [OrderW-1:0] ColorMono = 2'd2;

  // Register reset values
  localparam logic [CenterW-1:0] CenterXRst = 16'd5120;
  localparam logic [CenterW-1:0] CenterYRst = 16'd3840;
  localparam logic [ScaleW-1:0]  ScaleRst   = 40'd2199023;
  localparam logic [FrameW-1:0]  WidthRst   = 13'd640;
  localparam logic [FrameW-1:0]  HeightRst  = 13'd480;

  typedef struct packed {
    logic [CenterW-1:0] princ_col;
    logic [CenterW-1:0] princ_row;
    logic [ScaleW-1:0]  scale_x;
    logic [ScaleW-1:0]  scale_y;
    logic [FrameW-1:0]  frame_width;
    logic [FrameW-1:0]  frame_height;
    logic [OrderW-1:0]  color_order;
  } cfg_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic              neg_x;
    logic [MagW-1:0]   mag_x;
    logic              neg_y;
    logic [MagW-1:0]   mag_y;
    logic [DepthW-1:0] depth;
    logic [ByteW-1:0]  red;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  blue;
    logic              eor;
    logic              eof;
  } pixel_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ZW-1:0]     z;
    logic              valid;
    logic [ByteW-1:0]  red;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  blue;
    logic              eor;
    logic              eof;
  } point_t;

  typedef struct packed {
    logic [OutCntW-1:0] out_cnt;
    logic [1:0]         inflight;
  } back_stat_t;

endpackage

`default_nettype wire

[sv/dtcp_front.sv]
// Front end: pixel position counters, offsets from the principal point, color routing.
`default_nettype none

module dtcp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dtcp_pkg::cfg_t              cfg_i,
  input  logic                        push_i,
  input  logic                        full_i,
  input  logic [dtcp_pkg::DepthW-1:0] depth_mm_i,
  input  logic [dtcp_pkg::ByteW-1:0]  byte0_i,
  input  logic [dtcp_pkg::ByteW-1:0]  byte1_i,
  input  logic [dtcp_pkg::ByteW-1:0]  byte2_i,
  output logic                        q_push_o,
  output dtcp_pkg::pixel_t            pixel_o
);
  import dtcp_pkg::*;

  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [CntW-1:0] col_last, row_last;
  logic            eor, eof, accept;
  logic [MagW:0]   off_x, off_y;

  // last index of a clamped dimension
  function automatic logic [CntW-1:0] last_index(logic [FrameW-1:0] dim);
    logic [LimW-1:0] d;
    d = LimW'(dim);
    if (d == '0) begin
      d = LimW'(1);
    end else if (d > LimW'(MaxDim)) begin
      d = LimW'(MaxDim);
    end
    return CntW'(d - LimW'(1));
  endfunction

  // {sign, magnitude} of pos*16 - center
  function automatic logic [MagW:0] offset(logic [CntW-1:0] pos,
                                           logic [CenterW-1:0] center);
    logic [MagW-1:0] p16;
    logic [MagW-1:0] c;
    p16 = MagW'({pos, {SubPixW{1'b0}}});
    c   = MagW'(center);
    if (p16 < c) begin
      return {1'b1, c - p16};
    end
    return {1'b0, p16 - c};
  endfunction

  assign accept   = push_i && !full_i;
  assign q_push_o = accept;

  assign col_last = last_index(cfg_i.frame_width);
  assign row_last = last_index(cfg_i.frame_height);
  assign eor      = col_q >= col_last;
  assign eof      = eor && (row_q >= row_last);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (eor) begin
        col_d = '0;
        row_d = eof ? '0 : row_q + CntW'(1);
      end else begin
        col_d = col_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign off_x = offset(col_q, cfg_i.princ_col);
  assign off_y = offset(row_q, cfg_i.princ_row);

  always_comb begin
    pixel_o.neg_x = off_x[MagW];
    pixel_o.mag_x = off_x[MagW-1:0];
    pixel_o.neg_y = off_y[MagW];
    pixel_o.mag_y = off_y[MagW-1:0];
    pixel_o.depth = depth_mm_i;
    pixel_o.eor   = eor;
    pixel_o.eof   = eof;
    unique case (cfg_i.color_order)
      ColorBgr: begin
        pixel_o.red   = byte2_i;
        pixel_o.green = byte1_i;
        pixel_o.blue  = byte0_i;
      end
      ColorMono: begin
        pixel_o.red   = byte0_i;
        pixel_o.green = byte0_i;
        pixel_o.blue  = byte0_i;
      end
      default: begin
        pixel_o.red   = byte0_i;
        pixel_o.green = byte1_i;
        pixel_o.blue  = byte2_i;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/dtcp_queue.sv]
// Two-entry queue of classified pixels between front and back.
`default_nettype none

module dtcp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dtcp_pkg::pixel_t data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output dtcp_pkg::pixel_t data_o
);
  import dtcp_pkg::*;

  pixel_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QCntW-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPtrW'(1);
      if (do_pop)  rd_q <= rd_q + QPtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[sv/dtcp_back.sv]
// Back end: projection multiply pipeline, rounding, saturation and result queue.
`default_nettype none

module dtcp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dtcp_pkg::ScaleW-1:0] scale_x_i,
  input  logic [dtcp_pkg::ScaleW-1:0] scale_y_i,
  input  logic                        q_empty_i,
  input  dtcp_pkg::pixel_t            pixel_i,
  output logic                        q_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output dtcp_pkg::point_t            point_o,
  output dtcp_pkg::back_stat_t        stat_o
);
  import dtcp_pkg::*;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic             eor;
    logic             eof;
  } side_t;

  // Stage A: offset * depth, z reciprocal multiply
  logic              va_q;
  logic              a_neg_x_q, a_neg_y_q;
  logic [ProdW-1:0]  a_prod_x_q, a_prod_y_q;
  logic [ZW-1:0]     a_z_q;
  side_t             a_side_q;
  logic [ZNumW-1:0]  znum;
  logic [ZProdW-1:0] zprod;

  // Stage B: split scale products
  logic              vb_q;
  logic              b_neg_x_q, b_neg_y_q;
  logic [AW-1:0]     b_hi_x_q, b_lo_x_q, b_hi_y_q, b_lo_y_q;
  logic [ZW-1:0]     b_z_q;
  side_t             b_side_q;

  // Stage C: rounded low part and high part, summed and saturated after
  logic              vc_q;
  logic              c_neg_x_q, c_neg_y_q;
  logic [AHiW-1:0]   c_ahi_x_q, c_ahi_y_q;
  logic [LowHiW-1:0] c_lhi_x_q, c_lhi_y_q;
  logic [ZW-1:0]     c_z_q;
  side_t             c_side_q;
  logic [LowW-1:0]   low_x, low_y;
  point_t            result;

  // Result queue
  point_t              ofifo_q [OutDepth];
  logic [OutPtrW-1:0]  owr_q, ord_q;
  logic [OutCntW-1:0]  ocnt_q;
  logic [1:0]          inflight;
  logic [OutCntW:0]    committed;
  logic                take, do_pop;

  function automatic logic [LowW-1:0] round_low(logic [AW-1:0] hi, logic [AW-1:0] lo);
    return LowW'({hi[ASplit-1:0], {ScaleHalfW{1'b0}}}) + LowW'(lo)
           + (LowW'(1) << (DropW - 1));
  endfunction

  function automatic logic [CoordW-1:0] saturate(logic neg, logic [QW-1:0] q);
    logic [QW-1:0] lim;
    lim = QW'(1) << (CoordW - 1);
    if (neg) begin
      if (q >= lim) return {1'b1, {(CoordW-1){1'b0}}};
      return ~q[CoordW-1:0] + CoordW'(1);
    end
    if (q >= lim) return {1'b0, {(CoordW-1){1'b1}}};
    return q[CoordW-1:0];
  endfunction

  // Only draw a pixel when the result queue has a slot for everything in flight.
  assign inflight  = 2'(va_q) + 2'(vb_q) + 2'(vc_q);
  assign committed = (OutCntW+1)'(ocnt_q) + (OutCntW+1)'(inflight);
  assign take      = !q_empty_i && (committed < (OutCntW+1)'(OutDepth));
  assign q_pop_o   = take;

  assign znum  = {pixel_i.depth, {ZFracW{1'b0}}} | ZBias;
  assign zprod = ZProdW'(znum) * ZProdW'(ZRecip);

  always_ff @(posedge clk_i) begin
    a_neg_x_q  <= pixel_i.neg_x;
    a_neg_y_q  <= pixel_i.neg_y;
    a_prod_x_q <= ProdW'(pixel_i.mag_x) * ProdW'(pixel_i.depth);
    a_prod_y_q <= ProdW'(pixel_i.mag_y) * ProdW'(pixel_i.depth);
    a_z_q      <= zprod[ZShift +: ZW];
    a_side_q   <= '{valid: pixel_i.depth != '0, red: pixel_i.red,
                    green: pixel_i.green, blue: pixel_i.blue,
                    eor: pixel_i.eor, eof: pixel_i.eof};

    b_neg_x_q  <= a_neg_x_q;
    b_neg_y_q  <= a_neg_y_q;
    b_hi_x_q   <= AW'(a_prod_x_q) * AW'(scale_x_i[ScaleW-1:ScaleHalfW]);
    b_lo_x_q   <= AW'(a_prod_x_q) * AW'(scale_x_i[ScaleHalfW-1:0]);
    b_hi_y_q   <= AW'(a_prod_y_q) * AW'(scale_y_i[ScaleW-1:ScaleHalfW]);
    b_lo_y_q   <= AW'(a_prod_y_q) * AW'(scale_y_i[ScaleHalfW-1:0]);
    b_z_q      <= a_z_q;
    b_side_q   <= a_side_q;

    c_neg_x_q  <= b_neg_x_q;
    c_neg_y_q  <= b_neg_y_q;
    c_ahi_x_q  <= b_hi_x_q[AW-1:ASplit];
    c_ahi_y_q  <= b_hi_y_q[AW-1:ASplit];
    c_lhi_x_q  <= low_x[LowW-1:DropW];
    c_lhi_y_q  <= low_y[LowW-1:DropW];
    c_z_q      <= b_z_q;
    c_side_q   <= b_side_q;
  end

  assign low_x = round_low(b_hi_x_q, b_lo_x_q);
  assign low_y = round_low(b_hi_y_q, b_lo_y_q);

  always_comb begin
    result.x     = saturate(c_neg_x_q, QW'(c_ahi_x_q) + QW'(c_lhi_x_q));
    result.y     = saturate(c_neg_y_q, QW'(c_ahi_y_q) + QW'(c_lhi_y_q));
    result.z     = c_z_q;
    result.valid = c_side_q.valid;
    result.red   = c_side_q.red;
    result.green = c_side_q.green;
    result.blue  = c_side_q.blue;
    result.eor   = c_side_q.eor;
    result.eof   = c_side_q.eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= take;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign empty_o = ocnt_q == '0;
  assign do_pop  = pop_i && !empty_o;
  assign point_o = ofifo_q[ord_q];

  always_ff @(posedge clk_i) begin
    if (vc_q) begin
      ofifo_q[owr_q] <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= '0;
      ord_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (vc_q)   owr_q <= owr_q + OutPtrW'(1);
      if (do_pop) ord_q <= ord_q + OutPtrW'(1);
      if (vc_q && !do_pop) begin
        ocnt_q <= ocnt_q + OutCntW'(1);
      end else if (do_pop && !vc_q) begin
        ocnt_q <= ocnt_q - OutCntW'(1);
      end
    end
  end

  assign stat_o.out_cnt  = ocnt_q;
  assign stat_o.inflight = inflight;

endmodule

`default_nettype wire

[sv/depth_to_colored_point_core.sv]
// Top level: configuration registers, front end, pixel queue and back end.
// Turns a raster stream of depth + color pixels into colored 3-D points
// through a pinhole camera model.
// Input channel: a pixel request is taken at a clock edge with push high
//   and full low. Column/row position is counted internally and wraps at
//   the configured frame size.
// Result channel: while empty is low the oldest point is on the result
//   ports; it is taken at an edge with pop high. One point per pixel,
//   in order.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_wdata_i on
//   the same edge; write only while no pixel is in flight. Unknown indexes
//   are ignored.
// Timing: a pixel passes the pixel queue, three pipeline stages, then the
//   result queue before it can be popped. Throughput is one pixel per clock
//   while results are popped, set by the pipelined multipliers.
// Reset: registers return to their defaults, counters to column 0 row 0,
//   both queues empty.
// Stall: the result queue holds eight points; the back end stops drawing
//   when results plus points in flight would overfill it, the two-entry
//   pixel queue then fills and full rises.
`default_nettype none

module depth_to_colored_point_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dtcp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dtcp_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic [dtcp_pkg::DepthW-1:0]   depth_mm_i,
  input  logic [dtcp_pkg::ByteW-1:0]    byte0_i,
  input  logic [dtcp_pkg::ByteW-1:0]    byte1_i,
  input  logic [dtcp_pkg::ByteW-1:0]    byte2_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [dtcp_pkg::CoordW-1:0]   x_pos_o,
  output logic [dtcp_pkg::CoordW-1:0]   y_pos_o,
  output logic [dtcp_pkg::ZW-1:0]       z_pos_o,
  output logic                          point_valid_o,
  output logic [dtcp_pkg::ByteW-1:0]    red_o,
  output logic [dtcp_pkg::ByteW-1:0]    green_o,
  output logic [dtcp_pkg::ByteW-1:0]    blue_o,
  output logic                          end_of_row_o,
  output logic                          end_of_frame_o
);
  import dtcp_pkg::*;

  cfg_t       cfg_q;
  logic       q_push, q_full, q_empty, take;
  pixel_t     front_pixel, head_pixel;
  point_t     point;
  back_stat_t bstat;

  // Configuration registers; fields keep only their own width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.princ_col    <= CenterXRst;
      cfg_q.princ_row    <= CenterYRst;
      cfg_q.scale_x      <= ScaleRst;
      cfg_q.scale_y      <= ScaleRst;
      cfg_q.frame_width  <= WidthRst;
      cfg_q.frame_height <= HeightRst;
      cfg_q.color_order  <= ColorRgb;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCenterX:     cfg_q.princ_col    <= cfg_wdata_i[CenterW-1:0];
        RegCenterY:     cfg_q.princ_row    <= cfg_wdata_i[CenterW-1:0];
        RegScaleX:      cfg_q.scale_x      <= cfg_wdata_i[ScaleW-1:0];
        RegScaleY:      cfg_q.scale_y      <= cfg_wdata_i[ScaleW-1:0];
        RegFrameWidth:  cfg_q.frame_width  <= cfg_wdata_i[FrameW-1:0];
        RegFrameHeight: cfg_q.frame_height <= cfg_wdata_i[FrameW-1:0];
        RegColorOrder:  cfg_q.color_order  <= cfg_wdata_i[OrderW-1:0];
        default: ;
      endcase
    end
  end

  // Front: position, offsets, color routing
  dtcp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .full_i     (q_full),
    .depth_mm_i (depth_mm_i),
    .byte0_i    (byte0_i),
    .byte1_i    (byte1_i),
    .byte2_i    (byte2_i),
    .q_push_o   (q_push),
    .pixel_o    (front_pixel)
  );

  assign full = q_full;

  // Decouples the front from back-end stalls
  dtcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_pixel),
    .pop_i   (take),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (head_pixel)
  );

  // Back: projection arithmetic and result queue
  dtcp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .scale_x_i (cfg_q.scale_x),
    .scale_y_i (cfg_q.scale_y),
    .q_empty_i (q_empty),
    .pixel_i   (head_pixel),
    .q_pop_o   (take),
    .pop_i     (pop),
    .empty_o   (empty),
    .point_o   (point),
    .stat_o    (bstat)
  );

  assign x_pos_o        = point.x;
  assign y_pos_o        = point.y;
  assign z_pos_o        = point.z;
  assign point_valid_o  = point.valid;
  assign red_o          = point.red;
  assign green_o        = point.green;
  assign blue_o         = point.blue;
  assign end_of_row_o   = point.eor;
  assign end_of_frame_o = point.eof;

  // The back end never draws from an empty pixel queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) take |-> !q_empty)
    else $error("back end drew from empty pixel queue");

  // Results waiting plus points in flight never exceed the result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((OutCntW+1)'(bstat.out_cnt) + (OutCntW+1)'(bstat.inflight))
      <= (OutCntW+1)'(OutDepth))
    else $error("result queue overcommitted");

  // End of frame is always also end of row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && end_of_frame_o) |-> end_of_row_o)
    else $error("end of frame without end of row");

endmodule

`default_nettype wire
